// ----- design/spce_pkg.sv -----
package spce_pkg;

  // Default sizes
  localparam int NodesDef    = 64;
  localparam int CostBitsDef = 16;

  // Largest reportable path cost
  localparam logic [21:0] PathMax = 22'h3FFFFF;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_NOROUTE = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  link_from;
    logic [5:0]  link_to;
    logic [15:0] link_weight;
    logic [5:0]  query_source;
    logic [5:0]  query_target;
  } item_t;

  typedef struct packed {
    logic [21:0] path_cost;
    logic [1:0]  status;
  } result_t;

endpackage

// ----- design/spce_ram.sv -----
module spce_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/spce_cell.sv -----
module spce_cell #(
  parameter int WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] entry_q;

  // Take the neighbour's entry whenever the ring advances
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ----- design/shortest_path_cost_engine.sv -----
// Single-pair shortest path engine over an undirected weighted graph of NODES
// nodes. Raise start with an item while busy is low; clear and add items give
// no result, a query gives exactly one result on result_o, marked by done_o for
// a single cycle, which must be taken then since the block cannot be held off.
// After reset and after every clear item, a sweep clears the link memory with
// busy high. An add item reads the stored link, then writes it both ways through
// the single write port of the link memory. A query whose node is absent, or
// whose source equals its target, answers in the cycle after it is taken.
// Otherwise each settled node costs one pass: the node's link row is read one
// entry a cycle and meets a ring of NODES distance cells rotating past one
// relax-and-compare unit, and the query ends when the target is settled or no
// reachable node is left to settle.
module shortest_path_cost_engine #(
  parameter int NODES     = spce_pkg::NodesDef,
  parameter int COST_BITS = spce_pkg::CostBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  spce_pkg::item_t   item_i,
  output logic              busy,
  output logic              done_o,
  output spce_pkg::result_t result_o
);

  import spce_pkg::*;

  localparam int DEPTH  = NODES * NODES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int DIST_W = COST_BITS + NODE_W;
  localparam int MEM_W  = COST_BITS + 1;
  localparam int ENT_W  = DIST_W + 2;
  localparam logic [COST_BITS-1:0] COST_MAX = '1;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ADD_RD = 3'd2;
  localparam logic [2:0] S_ADD_WI = 3'd3;
  localparam logic [2:0] S_ADD_WJ = 3'd4;
  localparam logic [2:0] S_PASS   = 3'd5;

  logic [2:0]           state_q, state_d;
  logic [ADDR_W-1:0]    ptr_q, ptr_d;
  logic [ADDR_W-1:0]    addr_j_q, addr_j_d;
  logic [COST_BITS-1:0] cost_q, cost_d;
  logic [MEM_W-1:0]     wval_q, wval_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NODE_W-1:0]    head_q, head_d;
  logic [NODE_W-1:0]    best_q, best_d;
  logic [NODE_W-1:0]    tgt_q, tgt_d;
  logic [DIST_W-1:0]    bd_q, bd_d;
  logic                 first_q, first_d;
  logic                 any_q, any_d;
  logic [DIST_W-1:0]    mind_q, mind_d;
  logic [NODE_W-1:0]    mini_q, mini_d;
  logic [NODES-1:0]     node_present_q, node_present_d;
  logic                 rd_vld_q, rd_vld_d;
  logic                 done_q, done_d;
  result_t              res_q, res_d;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [MEM_W-1:0]     mem_wdata;
  logic [MEM_W-1:0]     mem_rdata;

  logic [ENT_W-1:0]     ring_q [NODES];
  logic [ENT_W-1:0]     head_new;

  // Head-of-ring relax and compare
  logic                 h_vis, h_reach, n_vis, n_reach, cand;
  logic [DIST_W-1:0]    h_dist, n_dist, nd;
  logic                 m_pres;
  logic [COST_BITS-1:0] m_cost;
  logic                 any_n;
  logic [DIST_W-1:0]    mind_n;
  logic [NODE_W-1:0]    mini_n;

  // Decoded item
  logic [COST_BITS-1:0] wsat;
  logic                 add_ok, src_ok, tgt_ok;
  logic [NODE_W-1:0]    a_idx, b_idx, s_idx, t_idx;
  logic                 upd;
  logic [MEM_W-1:0]     wi_val;

  spce_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  // Ring of distance cells, rotating towards cell zero
  for (genvar g = 0; g < NODES; g++) begin : g_ring
    logic [ENT_W-1:0] cell_d;
    if (g == NODES - 1) begin : g_tail
      assign cell_d = head_new;
    end else begin : g_mid
      assign cell_d = ring_q[g+1];
    end
    spce_cell #(
      .WIDTH (ENT_W)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (rd_vld_q),
      .d_i   (cell_d),
      .q_o   (ring_q[g])
    );
  end

  // Relax the head node against the current row entry, then track the minimum
  always_comb begin
    h_dist  = ring_q[0][DIST_W-1:0];
    h_reach = !first_q && ring_q[0][DIST_W];
    h_vis   = !first_q && ring_q[0][DIST_W+1];
    m_pres  = mem_rdata[COST_BITS];
    m_cost  = mem_rdata[COST_BITS-1:0];
    nd      = bd_q + DIST_W'(m_cost);
    n_dist  = h_dist;
    n_reach = h_reach;
    n_vis   = h_vis;
    if (head_q == best_q) begin
      n_vis   = 1'b1;
      n_reach = 1'b1;
      n_dist  = bd_q;
    end else if (m_pres && !h_vis) begin
      if (!h_reach || nd < h_dist) begin
        n_dist  = nd;
        n_reach = 1'b1;
      end
    end
    head_new = {n_vis, n_reach, n_dist};
    cand     = n_reach && !n_vis && (!any_q || n_dist < mind_q);
    any_n    = any_q;
    mind_n   = mind_q;
    mini_n   = mini_q;
    if (cand) begin
      any_n  = 1'b1;
      mind_n = n_dist;
      mini_n = head_q;
    end
  end

  // Decode the incoming item
  always_comb begin
    a_idx  = NODE_W'(item_i.link_from);
    b_idx  = NODE_W'(item_i.link_to);
    s_idx  = NODE_W'(item_i.query_source);
    t_idx  = NODE_W'(item_i.query_target);
    add_ok = (32'(item_i.link_from) < 32'(NODES)) && (32'(item_i.link_to) < 32'(NODES));
    src_ok = (32'(item_i.query_source) < 32'(NODES)) && node_present_q[s_idx];
    tgt_ok = (32'(item_i.query_target) < 32'(NODES)) && node_present_q[t_idx];
    if (32'(item_i.link_weight) > 32'(COST_MAX)) begin
      wsat = COST_MAX;
    end else begin
      wsat = COST_BITS'(item_i.link_weight);
    end
    upd    = !mem_rdata[COST_BITS] || mem_rdata[COST_BITS-1:0] > cost_q;
    wi_val = upd ? {1'b1, cost_q} : {1'b1, mem_rdata[COST_BITS-1:0]};
  end

  // Link memory writes: clearing sweep and the two halves of an add
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = '0;
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_ADD_WI: begin
        mem_we    = 1'b1;
        mem_wdata = wi_val;
      end
      S_ADD_WJ: begin
        mem_we    = 1'b1;
        mem_waddr = addr_j_q;
        mem_wdata = wval_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d        = state_q;
    ptr_d          = ptr_q;
    addr_j_d       = addr_j_q;
    cost_d         = cost_q;
    wval_d         = wval_q;
    cnt_d          = cnt_q;
    head_d         = head_q;
    best_d         = best_q;
    tgt_d          = tgt_q;
    bd_d           = bd_q;
    first_d        = first_q;
    any_d          = any_q;
    mind_d         = mind_q;
    mini_d         = mini_q;
    node_present_d = node_present_q;
    rd_vld_d       = 1'b0;
    done_d         = 1'b0;
    res_d          = res_q;
    unique case (state_q)
      S_CLR: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (item_i.kind)
            KIND_CLEAR: begin
              node_present_d = '0;
              ptr_d          = '0;
              state_d        = S_CLR;
            end
            KIND_ADD: begin
              if (add_ok) begin
                ptr_d    = ADDR_W'(a_idx) * ADDR_W'(NODES) + ADDR_W'(b_idx);
                addr_j_d = ADDR_W'(b_idx) * ADDR_W'(NODES) + ADDR_W'(a_idx);
                cost_d   = wsat;
                node_present_d[a_idx] = 1'b1;
                node_present_d[b_idx] = 1'b1;
                state_d  = S_ADD_RD;
              end
            end
            KIND_QUERY: begin
              if (!src_ok || !tgt_ok) begin
                done_d = 1'b1;
                res_d  = '{path_cost: '0, status: ST_ABSENT};
              end else if (s_idx == t_idx) begin
                done_d = 1'b1;
                res_d  = '{path_cost: '0, status: ST_FOUND};
              end else begin
                best_d  = s_idx;
                tgt_d   = t_idx;
                bd_d    = '0;
                first_d = 1'b1;
                any_d   = 1'b0;
                ptr_d   = ADDR_W'(s_idx) * ADDR_W'(NODES);
                cnt_d   = '0;
                head_d  = '0;
                state_d = S_PASS;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        state_d = S_ADD_WI;
      end
      S_ADD_WI: begin
        wval_d  = wi_val;
        state_d = S_ADD_WJ;
      end
      S_ADD_WJ: begin
        state_d = S_IDLE;
      end
      S_PASS: begin
        cnt_d = cnt_q + 1'b1;
        if (32'(cnt_q) < 32'(NODES)) begin
          ptr_d    = ptr_q + 1'b1;
          rd_vld_d = 1'b1;
        end
        if (rd_vld_q) begin
          head_d = head_q + 1'b1;
          any_d  = any_n;
          mind_d = mind_n;
          mini_d = mini_n;
        end
        if (32'(cnt_q) == 32'(NODES)) begin
          // Settle the next node, or finish
          if (!any_n) begin
            done_d  = 1'b1;
            res_d   = '{path_cost: '0, status: ST_NOROUTE};
            state_d = S_IDLE;
          end else if (mini_n == tgt_q) begin
            done_d = 1'b1;
            res_d.status = ST_FOUND;
            if (64'(mind_n) > 64'(PathMax)) begin
              res_d.path_cost = PathMax;
            end else begin
              res_d.path_cost = 22'(mind_n);
            end
            state_d = S_IDLE;
          end else begin
            best_d  = mini_n;
            bd_d    = mind_n;
            first_d = 1'b0;
            any_d   = 1'b0;
            ptr_d   = ADDR_W'(mini_n) * ADDR_W'(NODES);
            cnt_d   = '0;
            head_d  = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      ptr_q          <= '0;
      cnt_q          <= '0;
      head_q         <= '0;
      first_q        <= 1'b1;
      any_q          <= 1'b0;
      node_present_q <= '0;
      rd_vld_q       <= 1'b0;
      done_q         <= 1'b0;
    end else begin
      state_q        <= state_d;
      ptr_q          <= ptr_d;
      cnt_q          <= cnt_d;
      head_q         <= head_d;
      first_q        <= first_d;
      any_q          <= any_d;
      node_present_q <= node_present_d;
      rd_vld_q       <= rd_vld_d;
      done_q         <= done_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    addr_j_q <= addr_j_d;
    cost_q   <= cost_d;
    wval_q   <= wval_d;
    best_q   <= best_d;
    tgt_q    <= tgt_d;
    bd_q     <= bd_d;
    mind_q   <= mind_d;
    mini_q   <= mini_d;
    res_q    <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // A result follows a pass or a query answered at once
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == S_PASS) || $past(start && state_q == S_IDLE))
    else $error("result without a query");

  // Pass counter stays within one row
  a_cnt_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PASS |-> 32'(cnt_q) <= 32'(NODES))
    else $error("pass counter overran");

  // Only a found result carries a cost
  a_cost_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.status != ST_FOUND |-> res_q.path_cost == '0)
    else $error("cost on a failed query");

  // Row reads arrive only during a pass
  a_rd_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == S_PASS)
    else $error("row data outside a pass");

endmodule

// ----- test/path_cost_checker.sv -----
`timescale 1ns / 100ps

module path_cost_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  spce_pkg::item_t   item_i,
  input  logic              done_i,
  input  spce_pkg::result_t result_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                queries_o
);

  import spce_pkg::*;

  localparam int N = NodesDef;

  logic [15:0] link_cost [N][N];
  logic        link_on   [N][N];
  logic [N-1:0] node_on;
  result_t     cost_queue [$];

  // Store a link both ways, keep the cheaper cost
  task automatic store_link(input logic [5:0] a, input logic [5:0] b,
                            input logic [15:0] w);
    if (!link_on[a][b] || link_cost[a][b] > w) begin
      link_cost[a][b] = w;
      link_cost[b][a] = w;
    end
    link_on[a][b] = 1'b1;
    link_on[b][a] = 1'b1;
    node_on[a] = 1'b1;
    node_on[b] = 1'b1;
  endtask

  // Work out least cost from s to t by array Dijkstra
  function automatic result_t least_cost(input logic [5:0] s, input logic [5:0] t);
    result_t r;
    logic [31:0] tent_cost [N];
    logic [N-1:0] seen;
    logic [N-1:0] done;
    int best;
    logic [31:0] nd;
    r.path_cost = '0;
    if (!node_on[s] || !node_on[t]) begin
      r.status = ST_ABSENT;
      return r;
    end
    r.status = ST_FOUND;
    if (s == t) return r;
    seen = '0;
    done = '0;
    for (int n = 0; n < N; n++) tent_cost[n] = '0;
    seen[s] = 1'b1;
    // Each round settles one node, so N rounds always suffice
    for (int step = 0; step <= N; step++) begin
      best = -1;
      for (int n = 0; n < N; n++)
        if (seen[n] && !done[n] && (best < 0 || tent_cost[n] < tent_cost[best])) best = n;
      if (best < 0) begin
        r.status = ST_NOROUTE;
        return r;
      end
      if (best == t) begin
        r.path_cost = (tent_cost[best] > PathMax) ? PathMax : tent_cost[best][21:0];
        return r;
      end
      done[best] = 1'b1;
      for (int k = 0; k < N; k++) begin
        if (!link_on[best][k] || done[k]) continue;
        nd = tent_cost[best] + link_cost[best][k];
        if (!seen[k] || nd < tent_cost[k]) begin
          tent_cost[k] = nd;
          seen[k] = 1'b1;
        end
      end
    end
    r.status = ST_NOROUTE;
    return r;
  endfunction

  // Predict on accepted items, compare each strobed result
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      node_on = '0;
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++) link_on[i][j] = 1'b0;
    end else begin
      if (done_i) begin
        if (cost_queue.size() == 0) begin
          $display("%0t: unexpected result cost=%0d status=%0d", $time,
                   result_i.path_cost, result_i.status);
          fail_count_o++;
        end else begin
          want = cost_queue.pop_front();
          if (want.path_cost !== result_i.path_cost || want.status !== result_i.status) begin
            $display("%0t: expected cost=%0d status=%0d, got cost=%0d status=%0d",
                     $time, want.path_cost, want.status,
                     result_i.path_cost, result_i.status);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        case (item_i.kind)
          KIND_CLEAR: begin
            node_on = '0;
            for (int i = 0; i < N; i++)
              for (int j = 0; j < N; j++) link_on[i][j] = 1'b0;
          end
          KIND_ADD: store_link(item_i.link_from, item_i.link_to, item_i.link_weight);
          KIND_QUERY: begin
            cost_queue = {cost_queue,
                          least_cost(item_i.query_source, item_i.query_target)};
            queries_o++;
          end
          default: ;
        endcase
      end
    end
    pending_o = cost_queue.size();
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import spce_pkg::*;

  localparam int WatchLimit = 200000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  item_t   item = '0;
  logic    busy;
  logic    done;
  result_t result;
  int      fails;
  int      pending;
  int      queries;
  int      idle_pct = 0;
  int      idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  shortest_path_cost_engine uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .item_i(item),
    .busy(busy), .done_o(done), .result_o(result)
  );

  path_cost_checker checker_i (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy),
    .item_i(item), .done_i(done), .result_i(result),
    .fail_count_o(fails), .pending_o(pending), .queries_o(queries)
  );

  // Count cycles with nothing accepted or answered; stop a hung run
  always @(posedge clk_i) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Random filler for the fields an item kind ignores
  function automatic item_t rand_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  // Present one item, hold it until taken, with random gaps first
  task automatic send(input item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Drop start and hold off until every outstanding answer is back
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_add(input logic [5:0] a, input logic [5:0] b,
                          input logic [15:0] w);
    item_t it;
    it = rand_item();
    it.kind = KIND_ADD;
    it.link_from = a;
    it.link_to = b;
    it.link_weight = w;
    send(it);
  endtask

  task automatic send_query(input logic [5:0] s, input logic [5:0] t);
    item_t it;
    it = rand_item();
    it.kind = KIND_QUERY;
    it.query_source = s;
    it.query_target = t;
    send(it);
  endtask

  task automatic send_kind(input logic [1:0] k);
    item_t it;
    it = rand_item();
    it.kind = k;
    send(it);
  endtask

  // Random item over nodes 0 to pool; a small pool lets routes form
  task automatic send_random(input int pool);
    int r;
    r = $urandom_range(99);
    if (r < 3) send_kind(KIND_CLEAR);
    else if (r < 5) send_kind(KIND_UNUSED);
    else if (r < 60)
      send_add(6'($urandom_range(pool)), 6'($urandom_range(pool)),
               ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(50)));
    else send_query(6'($urandom_range(pool)), 6'($urandom_range(pool)));
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: absent nodes, extremes, self link, duplicate links, no route
    send_query(6'd0, 6'd63);
    send_add(6'd0, 6'd63, 16'hFFFF);
    send_query(6'd0, 6'd63);
    send_query(6'd63, 6'd63);
    send_add(6'd0, 6'd63, 16'd5);
    send_add(6'd0, 6'd63, 16'd9);
    send_query(6'd63, 6'd0);
    send_add(6'd10, 6'd10, 16'd0);
    send_query(6'd10, 6'd10);
    send_query(6'd10, 6'd0);
    send_add(6'd63, 6'd42, 16'hFFFF);
    send_add(6'd42, 6'd21, 16'hFFFF);
    send_query(6'd0, 6'd21);
    send_add(6'd0, 6'd21, 16'd0);
    send_query(6'd0, 6'd42);
    send_kind(KIND_UNUSED);
    send_query(6'd5, 6'd5);
    send_kind(KIND_CLEAR);
    send_query(6'd0, 6'd63);
    send_add(6'd1, 6'd2, 16'h5555);
    send_add(6'd2, 6'd3, 16'hAAAA);
    send_query(6'd1, 6'd3);
    send_query(6'd3, 6'd0);

    // Random phases with changing idle rates
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 45;
        2: idle_pct = 0;
        default: idle_pct = 37;
      endcase
      for (int i = 0; i < 30; i++) send_random((ph == 3) ? 63 : 11);
      // Hold off until every outstanding answer is back
      drain();
    end

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Sent directed and four random phases; %0d queries answered.", queries);
    $display("Covered clears, unused kind, self links, saturating weights, no route.");
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
